// File: design/lswd_pkg.sv
// Shared types, constants and CRC step function for the leap second word decoder.
// No dependencies.
package lswd_pkg;

  localparam int          LswdMsgBits       = 28;
  localparam int          LswdStepsPerStage = 7;
  localparam int          LswdCrcStages     = LswdMsgBits / LswdStepsPerStage;
  localparam logic [31:0] LswdSeed          = 32'h54A9_ABF8;
  localparam logic [31:0] LswdPolyAlign     = 32'h9780_0000;
  localparam logic [7:0]  LswdCrcGood       = 8'h80;
  localparam logic [3:0]  LswdClassE        = 4'hF;
  localparam logic [11:0] LswdBaseYear      = 12'd1971;
  localparam logic [11:0] LswdCountBias     = 12'd10;
  localparam logic [11:0] LswdRecip12       = 12'd2731;
  localparam int          LswdRecipShift    = 15;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotClass = 2'd1;
  localparam logic [1:0] StCrcBad   = 2'd2;
  localparam logic [1:0] StBadCode  = 2'd3;

  localparam logic [1:0] CodeSame = 2'd0;
  localparam logic [1:0] CodeDown = 2'd1;
  localparam logic [1:0] CodeUp   = 2'd2;
  localparam logic [1:0] CodeBad  = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] crc;
  } lswd_beat_t;

  function automatic logic [31:0] lswd_crc_steps(input logic [31:0] r_in);
    logic [31:0] r;
    r = r_in;
    for (int i = 0; i < LswdStepsPerStage; i++) begin
      if (r[31]) begin
        r = r ^ LswdPolyAlign;
      end
      r = {r[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: design/lswd_crc_stage.sv
// One pipeline stage of the CRC check: a group of shift steps and a register.
// Uses lswd_pkg.
module lswd_crc_stage import lswd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  lswd_beat_t in_data,
  output logic       in_ready,
  output logic       out_valid,
  output lswd_beat_t out_data,
  input  logic       out_ready
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.word <= in_data.word;
      out_data.crc  <= lswd_crc_steps(in_data.crc);
    end
  end

endmodule

// File: design/lswd_finish.sv
// Last stage: status checks, month count split by 12, and the output register.
// Uses lswd_pkg.
module lswd_finish import lswd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  lswd_beat_t  in_data,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] horizon_year,
  output logic [3:0]  horizon_month,
  output logic [6:0]  utc_offset,
  output logic [1:0]  offset_change
);

  logic [11:0] count;
  logic [23:0] prod;
  logic [11:0] quot;
  logic [11:0] quot12;
  logic [3:0]  rem;
  logic [1:0]  code;
  logic [1:0]  status_next;
  logic [1:0]  change_next;

  assign code   = in_data.word[16:15];
  assign count  = {1'b0, in_data.word[27:17]} + LswdCountBias;
  assign prod   = count * LswdRecip12;
  assign quot   = 12'(prod >> LswdRecipShift);
  assign quot12 = {quot[8:0], 3'b000} + {quot[9:0], 2'b00};
  assign rem    = 4'(count - quot12);

  always_comb begin
    if (in_data.word[31:28] != LswdClassE) begin
      status_next = StNotClass;
    end else if (in_data.crc[31:24] != LswdCrcGood) begin
      status_next = StCrcBad;
    end else if (code == CodeBad) begin
      status_next = StBadCode;
    end else begin
      status_next = StOk;
    end
  end

  always_comb begin
    unique case (code)
      CodeDown: change_next = 2'b11;
      CodeUp:   change_next = 2'b01;
      default:  change_next = 2'b00;
    endcase
  end

  assign in_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      status <= status_next;
      if (status_next == StOk) begin
        horizon_year  <= LswdBaseYear + quot;
        horizon_month <= rem + 4'd1;
        utc_offset    <= in_data.word[14:8];
        offset_change <= change_next;
      end else begin
        horizon_year  <= '0;
        horizon_month <= '0;
        utc_offset    <= '0;
        offset_change <= '0;
      end
    end
  end

endmodule

// File: design/leap_second_word_decoder.sv
// Leap second announcement word decoder, top level.
// Uses lswd_pkg, lswd_crc_stage and lswd_finish.
//
// Each beat on address_word yields one result beat, passing through four register
// stages of seven CRC shift steps each and one stage for the checks, the divide
// by 12 and the output register.
// A new beat is taken every cycle unless the stall reaches back to the input; each stage holds
// its beat only while the stage after it is full and stalled, so bubbles close up under stall.
module leap_second_word_decoder import lswd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] address_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] horizon_year,
  output logic [3:0]  horizon_month,
  output logic [6:0]  utc_offset,
  output logic [1:0]  offset_change
);

  lswd_beat_t beat  [LswdCrcStages+1];
  logic       valid [LswdCrcStages+1];
  logic       ready [LswdCrcStages+1];

  assign valid[0]     = in_valid;
  assign beat[0].word = address_word;
  assign beat[0].crc  = LswdSeed ^ {address_word[LswdMsgBits-1:0], 4'b0000};
  assign in_stall     = !ready[0];

  for (genvar g = 0; g < LswdCrcStages; g++) begin : g_crc
    lswd_crc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[g]),
      .in_data   (beat[g]),
      .in_ready  (ready[g]),
      .out_valid (valid[g+1]),
      .out_data  (beat[g+1]),
      .out_ready (ready[g+1])
    );
  end

  lswd_finish u_finish (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (valid[LswdCrcStages]),
    .in_data       (beat[LswdCrcStages]),
    .in_ready      (ready[LswdCrcStages]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .horizon_year  (horizon_year),
    .horizon_month (horizon_month),
    .utc_offset    (utc_offset),
    .offset_change (offset_change)
  );

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output not blocked");

  a_ok_month_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == StOk) |-> (horizon_month >= 4'd1 && horizon_month <= 4'd12))
    else $error("month out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != StOk) |->
      (horizon_year == '0 && horizon_month == '0 && utc_offset == '0 &&
       offset_change == '0))
    else $error("value fields not zero on error");

  a_ok_change: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == StOk) |-> (offset_change != 2'b10))
    else $error("illegal offset change");

endmodule

// File: tb/leap_second_word_decoder_tb.sv
// Self-checking testbench for leap_second_word_decoder: directed rows, then random address
// words under several idle/stall mixes, each checked against a row's want or local decoder.
// Depends on lswd_pkg and leap_second_word_decoder.
module leap_second_word_decoder_tb;
  import lswd_pkg::*;

  localparam logic [31:0] CrcSeed    = 32'h54A9_ABF8;
  localparam logic [31:0] CrcPolyTop = 32'h9780_0000;
  localparam logic [7:0]  CrcGood    = 8'h80;
  localparam logic [1:0]  CodeIllegal = 2'd3;
  localparam logic [1:0]  ChangeNone = 2'b00;
  localparam logic [1:0]  ChangeUp   = 2'b01;
  localparam logic [1:0]  ChangeDown = 2'b11;
  localparam int          RandomPerPhase = 238;
  localparam int          LongHoldCycles = 80;
  localparam int          CycleLimit = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] year;
    logic [3:0]  month;
    logic [6:0]  offset;
    logic [1:0]  change;
  } horizon_t;

  typedef enum logic [1:0] {RowRaw, RowSealed, RowBroken} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] word;
    logic        typed;
    horizon_t    want;
  } vector_row_t;

  // word layout: class nibble, month count, change code, offset, check byte
  localparam vector_row_t DirectedRows [17] = '{
    '{RowRaw,    32'h0000_0000, 1'b1, '{StNotClass, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowRaw,    32'hFFFF_FFFF, 1'b0, '0},
    '{RowRaw,    32'hEFFF_FFFF, 1'b1, '{StNotClass, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowRaw,    32'h7000_0000, 1'b1, '{StNotClass, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowRaw,    32'hF000_0000, 1'b0, '0},
    '{RowRaw,    32'h5555_AAAA, 1'b1, '{StNotClass, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowSealed, {4'hF, 11'd0, CodeSame, 7'd0, 8'h00}, 1'b1,
      '{StOk, 12'd1971, 4'd11, 7'd0, ChangeNone}},
    '{RowSealed, {4'hF, 11'd2047, CodeUp, 7'd127, 8'h00}, 1'b1,
      '{StOk, 12'd2142, 4'd6, 7'd127, ChangeUp}},
    '{RowSealed, {4'hF, 11'd2, CodeDown, 7'd37, 8'h00}, 1'b1,
      '{StOk, 12'd1972, 4'd1, 7'd37, ChangeDown}},
    '{RowSealed, {4'hF, 11'd1, CodeSame, 7'd1, 8'h00}, 1'b1,
      '{StOk, 12'd1971, 4'd12, 7'd1, ChangeNone}},
    '{RowSealed, {4'hF, 11'd1234, CodeDown, 7'd64, 8'h00}, 1'b0, '0},
    '{RowSealed, {4'hF, 11'd1000, CodeSame, 7'd85, 8'h00}, 1'b0, '0},
    '{RowSealed, {4'hF, 11'd777, CodeIllegal, 7'd5, 8'h00}, 1'b1,
      '{StBadCode, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowSealed, {4'hF, 11'd2047, CodeIllegal, 7'd127, 8'h00}, 1'b1,
      '{StBadCode, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowSealed, {4'hE, 11'd5, CodeSame, 7'd3, 8'h00}, 1'b1,
      '{StNotClass, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowBroken, {4'hF, 11'd100, CodeUp, 7'd10, 8'h00}, 1'b1,
      '{StCrcBad, 12'd0, 4'd0, 7'd0, ChangeNone}},
    '{RowBroken, {4'hF, 11'd0, CodeSame, 7'd0, 8'h00}, 1'b1,
      '{StCrcBad, 12'd0, 4'd0, 7'd0, ChangeNone}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] address_word = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [11:0] horizon_year;
  logic [3:0]  horizon_month;
  logic [6:0]  utc_offset;
  logic [1:0]  offset_change;

  logic        stim_typed = 1'b0;
  horizon_t    stim_want = '0;

  horizon_t    horizons_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  leap_second_word_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .address_word  (address_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .horizon_year  (horizon_year),
    .horizon_month (horizon_month),
    .utc_offset    (utc_offset),
    .offset_change (offset_change)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] check_byte_of(input logic [27:0] body);
    logic [31:0] acc;
    acc = CrcSeed ^ {body, 4'b0};
    for (int i = 0; i < 28; i++) begin
      if (acc[31]) begin
        acc = acc ^ CrcPolyTop;
      end
      acc = {acc[30:0], 1'b0};
    end
    return acc[31:24];
  endfunction

  function automatic horizon_t decode_word(input logic [31:0] w);
    horizon_t    h;
    int unsigned months;
    h = '0;
    months = w[27:17] + 10;
    if (w[31:28] != 4'hF) begin
      h.status = StNotClass;
    end else if (check_byte_of(w[27:0]) != CrcGood) begin
      h.status = StCrcBad;
    end else begin
      h.status = StOk;
      case (w[16:15])
        CodeSame: h.change = ChangeNone;
        CodeDown: h.change = ChangeDown;
        CodeUp:   h.change = ChangeUp;
        default:  h.status = StBadCode;
      endcase
      if (h.status == StOk) begin
        h.year   = 12'(1971 + months / 12);
        h.month  = 4'(1 + months % 12);
        h.offset = w[14:8];
      end
    end
    return h;
  endfunction

  // fill in the low byte so the check passes
  function automatic logic [31:0] seal_word(input logic [31:0] w);
    for (int b = 0; b < 256; b++) begin
      if (check_byte_of({w[27:8], b[7:0]}) == CrcGood) begin
        return {w[31:8], b[7:0]};
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned pick;
    pick = $urandom_range(99);
    w = {4'hF, 28'($urandom())};
    if (pick < 75) begin
      w = seal_word(w);
    end
    if (pick >= 60 && pick < 75) begin
      w = w ^ (32'h1 << $urandom_range(27));
    end else if (pick >= 88) begin
      w = $urandom();
    end
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w, input logic typed, input horizon_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      address_word <= $urandom();
    end
    @(negedge clk);
    in_valid <= 1'b1;
    address_word <= w;
    stim_typed <= typed;
    stim_want <= want;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LongHoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    horizon_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        horizons_due.push_back(stim_typed ? stim_want : decode_word(address_word));
      end
      if (out_valid && !out_stall) begin
        if (horizons_due.size() == 0) begin
          $error("result beat with no word pending");
          mismatches++;
        end else begin
          want = horizons_due.pop_front();
          check_field("status", want.status, status);
          check_field("horizon_year", want.year, horizon_year);
          check_field("horizon_month", want.month, horizon_month);
          check_field("utc_offset", want.offset, utc_offset);
          check_field("offset_change", want.change, offset_change);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [31:0] w;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DirectedRows[i]) begin
      case (DirectedRows[i].kind)
        RowSealed: w = seal_word(DirectedRows[i].word);
        RowBroken: w = seal_word(DirectedRows[i].word) ^ 32'h1;
        default:   w = DirectedRows[i].word;
      endcase
      send_word(w, DirectedRows[i].typed, DirectedRows[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          hold_req = 1'b1;
        end
        1: begin
          send_idle_pct = 46;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 46;
        end
        default: begin
          send_idle_pct = 12;
          stall_pct = 12;
        end
      endcase
      repeat (RandomPerPhase) send_word(random_word(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    stall_pct = 0;
    while (horizons_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
